FILE: rtl/core/assert_macros.svh
// assertion helpers, clocked, with and without a reset qualifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define TCC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define TCC_ASSERT(lbl, clk, rstn, prop)
`define TCC_ASSERT_NR(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/tccur_pkg.sv
package tccur_pkg;

  localparam int TEXT_COLS = 128;
  localparam int TEXT_ROWS = 64;

  localparam int ROW_W = 6;
  localparam int COL_W = 7;

  localparam logic [7:0]       COLS_8  = 8'(TEXT_COLS);
  localparam logic [6:0]       ROWS_7  = 7'(TEXT_ROWS);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(TEXT_ROWS - 1);
  localparam logic [ROW_W-1:0] ROW_HOME = ROW_W'(1);

  localparam logic [2:0] OP_GLYPH  = 3'd0;
  localparam logic [2:0] OP_ERASE  = 3'd1;
  localparam logic [2:0] OP_DRAW   = 3'd2;
  localparam logic [2:0] OP_SCROLL = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] CLS_NONE  = 3'd0;
  localparam logic [2:0] CLS_GLYPH = 3'd1;
  localparam logic [2:0] CLS_BS    = 3'd2;
  localparam logic [2:0] CLS_TAB   = 3'd3;
  localparam logic [2:0] CLS_NL    = 3'd4;
  localparam logic [2:0] CLS_FF    = 3'd5;
  localparam logic [2:0] CLS_CR    = 3'd6;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = 2;
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = 1;

  typedef struct packed {
    logic [2:0] cls;
    logic [6:0] chr;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [6:0]       glyph_code;
    logic [ROW_W-1:0] text_row;
    logic [COL_W-1:0] text_col;
    logic             last;
  } res_t;

endpackage

FILE: rtl/core/tccur_front.sv
module tccur_front
  import tccur_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] byte_in,
  output logic       full,
  output logic       q_valid,
  output cmd_t       q_data,
  input  logic       q_pop
);

  cmd_t                cmd;
  cmd_t                q_mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CQ_AW:0]      cnt_r, cnt_nxt;
  logic                wr, rd;

  // classify the byte
  always_comb begin
    cmd.chr = byte_in[6:0];
    cmd.cls = CLS_NONE;
    if (byte_in >= CH_SPACE && byte_in < CH_DEL) begin
      cmd.cls = CLS_GLYPH;
    end else begin
      unique case (byte_in)
        CH_BS:   cmd.cls = CLS_BS;
        CH_TAB:  cmd.cls = CLS_TAB;
        CH_NL:   cmd.cls = CLS_NL;
        CH_FF:   cmd.cls = CLS_FF;
        CH_CR:   cmd.cls = CLS_CR;
        default: cmd.cls = CLS_NONE;
      endcase
    end
  end

  assign full    = (cnt_r == (CQ_AW+1)'(CQ_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = q_mem_r[rp_r];

  // ignored bytes are taken but never queued
  assign wr = push && !full && (cmd.cls != CLS_NONE);
  assign rd = q_pop && q_valid;

  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (CQ_AW+1)'(wr) - (CQ_AW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_mem_r[wp_r] <= cmd;
    end
  end

endmodule

FILE: rtl/core/tccur_back.sv
module tccur_back
  import tccur_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_data,
  output logic q_pop,
  output logic empty,
  output res_t res,
  input  logic pop
);

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  res_t             plan_r [4];
  logic [2:0]       cnt_r, cnt_nxt, idx_r, idx_nxt;

  res_t             plan [4];
  logic [2:0]       n;
  logic             has_pre, do_move, scroll;
  res_t             pre;
  logic [6:0]       trow;
  logic [COL_W-1:0] tcol;
  logic [ROW_W-1:0] nrow;
  logic [7:0]       col_inc, tab_next;
  logic [6:0]       row_inc;

  logic             active, emit, last_emit, load;

  res_t             rf_mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] rwp_r, rrp_r;
  logic [RQ_AW:0]   rcnt_r;
  logic             rf_full, rf_pop;

  // work out the target of this command from the current cursor
  always_comb begin
    col_inc  = {1'b0, col_r} + 8'd1;
    row_inc  = {1'b0, row_r} + 7'd1;
    tab_next = {1'b0, col_r[6:3], 3'b000} + 8'd8;
    has_pre  = 1'b0;
    do_move  = 1'b1;
    pre      = '0;
    trow     = {1'b0, row_r};
    tcol     = '0;
    unique case (q_data.cls)
      CLS_GLYPH: begin
        has_pre        = 1'b1;
        pre.op         = OP_GLYPH;
        pre.glyph_code = q_data.chr;
        pre.text_row   = row_r;
        pre.text_col   = col_r;
        if (col_inc < COLS_8) begin
          tcol = col_inc[6:0];
        end else begin
          trow = row_inc;
        end
      end
      CLS_BS: begin
        do_move = (col_r != '0);
        tcol    = col_r - 7'd1;
      end
      CLS_TAB: begin
        if (tab_next >= COLS_8) begin
          trow = row_inc;
        end else begin
          tcol = tab_next[6:0];
        end
      end
      CLS_NL: begin
        trow = row_inc;
      end
      CLS_FF: begin
        has_pre = 1'b1;
        pre.op  = OP_CLEAR;
        trow    = {1'b0, ROW_HOME};
      end
      CLS_CR: begin
        trow = {1'b0, row_r};
      end
      default: begin
        do_move = 1'b0;
      end
    endcase
    scroll = (trow >= ROWS_7);
    nrow   = scroll ? ROW_MAX : trow[5:0];
  end

  // lay out the ordered result list
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      plan[i] = '0;
    end
    n = '0;
    if (has_pre) begin
      plan[n[1:0]] = pre;
      n = n + 3'd1;
    end
    if (do_move) begin
      plan[n[1:0]].op       = OP_ERASE;
      plan[n[1:0]].text_row = row_r;
      plan[n[1:0]].text_col = col_r;
      n = n + 3'd1;
      if (scroll) begin
        plan[n[1:0]].op = OP_SCROLL;
        n = n + 3'd1;
      end
      plan[n[1:0]].op       = OP_DRAW;
      plan[n[1:0]].text_row = nrow;
      plan[n[1:0]].text_col = tcol;
      n = n + 3'd1;
    end
    for (int i = 0; i < 4; i++) begin
      plan[i].last = (3'(i + 1) == n);
    end
  end

  assign active    = (idx_r != cnt_r);
  assign rf_full   = (rcnt_r == (RQ_AW+1)'(RQ_DEPTH));
  assign emit      = active && !rf_full;
  assign last_emit = emit && ((idx_r + 3'd1) == cnt_r);
  assign load      = q_valid && (!active || last_emit);
  assign q_pop     = load;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = n;
      idx_nxt = '0;
      if (do_move) begin
        row_nxt = nrow;
        col_nxt = tcol;
      end
    end else if (emit) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= ROW_HOME;
      col_r <= '0;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) begin
        plan_r[i] <= plan[i];
      end
    end
  end

  // result queue toward the consumer
  assign empty  = (rcnt_r == '0);
  assign res    = rf_mem_r[rrp_r];
  assign rf_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rwp_r  <= '0;
      rrp_r  <= '0;
      rcnt_r <= '0;
    end else begin
      rwp_r  <= emit ? rwp_r + 1'b1 : rwp_r;
      rrp_r  <= rf_pop ? rrp_r + 1'b1 : rrp_r;
      rcnt_r <= rcnt_r + (RQ_AW+1)'(emit) - (RQ_AW+1)'(rf_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rf_mem_r[rwp_r] <= plan_r[idx_r[1:0]];
    end
  end

endmodule

FILE: rtl/core/text_console_cursor_engine_top.sv
// channel   | ports                               | accepted when
// input     | in_push, in_full, in_byte_in        | in_push && !in_full
// result    | out_pop, out_empty, out_op .. last  | out_pop && !out_empty
//
// a byte gives 0 to 4 results, which the result sequencer hands on one result
// per cycle while the result queue has room; the front takes a byte every cycle
// while its four-entry command queue has room. reset puts the cursor at
// row 1, column 0 and empties both queues. a stalled result side fills the
// two-entry result queue, then the command queue, then raises in_full.
`include "assert_macros.svh"

module text_console_cursor_engine_top
  import tccur_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [7:0]       in_byte_in,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [2:0]       out_op,
  output logic [6:0]       out_glyph_code,
  output logic [ROW_W-1:0] out_text_row,
  output logic [COL_W-1:0] out_text_col,
  output logic             out_last
);

  logic q_valid, q_pop;
  cmd_t q_data;
  res_t res;

  tccur_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .byte_in (in_byte_in),
    .full    (in_full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  tccur_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .empty   (out_empty),
    .res     (res),
    .pop     (out_pop)
  );

  assign out_op         = res.op;
  assign out_glyph_code = res.glyph_code;
  assign out_text_row   = res.text_row;
  assign out_text_col   = res.text_col;
  assign out_last       = res.last;

  `TCC_ASSERT(a_prefix_not_last, clk, rst_n, (!out_empty && (out_op == OP_GLYPH || out_op == OP_CLEAR || out_op == OP_ERASE || out_op == OP_SCROLL)) |-> !out_last)
  `TCC_ASSERT(a_draw_is_last, clk, rst_n, (!out_empty && out_op == OP_DRAW) |-> out_last)
  `TCC_ASSERT(a_scroll_zero, clk, rst_n, (!out_empty && (out_op == OP_SCROLL || out_op == OP_CLEAR)) |-> (out_text_row == '0 && out_text_col == '0 && out_glyph_code == '0))
  `TCC_ASSERT(a_no_pop_empty_q, clk, rst_n, q_pop |-> q_valid)

endmodule

FILE: tb/text_console_cursor_engine_top_tb.sv
`timescale 1ns / 100ps

module text_console_cursor_engine_top_tb;
  import tccur_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 112;

  class cursor_cmd_checker;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    res_t due_cmds[$];
    res_t step_cmds[$];
    int errors;

    function new();
      cur_row = ROW_HOME;
      cur_col = '0;
      errors = 0;
    endfunction

    function void add_cmd(logic [2:0] op, logic [6:0] glyph, logic [ROW_W-1:0] row,
                          logic [COL_W-1:0] col);
      res_t c;
      c.op = op;
      c.glyph_code = glyph;
      c.text_row = row;
      c.text_col = col;
      c.last = 1'b0;
      step_cmds.push_back(c);
    endfunction

    // erase at the old place, scroll when the row runs off the bottom, draw at the new place
    function void move_cursor(int row, int col);
      add_cmd(OP_ERASE, '0, cur_row, cur_col);
      if (row >= TEXT_ROWS) begin
        add_cmd(OP_SCROLL, '0, '0, '0);
        row = TEXT_ROWS - 1;
      end
      cur_row = ROW_W'(row);
      cur_col = COL_W'(col);
      add_cmd(OP_DRAW, '0, cur_row, cur_col);
    endfunction

    function void note_byte(logic [7:0] b);
      int next_tab;
      step_cmds.delete();
      if (b >= CH_SPACE && b < CH_DEL) begin
        add_cmd(OP_GLYPH, b[6:0], cur_row, cur_col);
        if (int'(cur_col) + 1 < TEXT_COLS) move_cursor(int'(cur_row), int'(cur_col) + 1);
        else move_cursor(int'(cur_row) + 1, 0);
      end else if (b == CH_BS) begin
        if (cur_col != '0) move_cursor(int'(cur_row), int'(cur_col) - 1);
      end else if (b == CH_TAB) begin
        next_tab = (int'(cur_col) & ~7) + 8;
        if (next_tab >= TEXT_COLS) move_cursor(int'(cur_row) + 1, 0);
        else move_cursor(int'(cur_row), next_tab);
      end else if (b == CH_NL) begin
        move_cursor(int'(cur_row) + 1, 0);
      end else if (b == CH_FF) begin
        add_cmd(OP_CLEAR, '0, '0, '0);
        move_cursor(int'(ROW_HOME), 0);
      end else if (b == CH_CR) begin
        move_cursor(int'(cur_row), 0);
      end
      if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
      foreach (step_cmds[k]) due_cmds.push_back(step_cmds[k]);
    endfunction

    function void check_cmd(res_t got);
      res_t want;
      if (due_cmds.size() == 0) begin
        $error("unexpected result: op %0d row %0d col %0d", got.op, got.text_row, got.text_col);
        errors++;
        return;
      end
      want = due_cmds.pop_front();
      if (got.op !== want.op) begin
        $error("op: expected %0d, got %0d", want.op, got.op);
        errors++;
      end
      if (got.glyph_code !== want.glyph_code) begin
        $error("glyph_code: expected %0d, got %0d", want.glyph_code, got.glyph_code);
        errors++;
      end
      if (got.text_row !== want.text_row) begin
        $error("text_row: expected %0d, got %0d", want.text_row, got.text_row);
        errors++;
      end
      if (got.text_col !== want.text_col) begin
        $error("text_col: expected %0d, got %0d", want.text_col, got.text_col);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_push;
  logic             in_full;
  logic [7:0]       in_byte_in;
  logic             out_empty;
  logic             out_pop;
  logic [2:0]       out_op;
  logic [6:0]       out_glyph_code;
  logic [ROW_W-1:0] out_text_row;
  logic [COL_W-1:0] out_text_col;
  logic             out_last;

  cursor_cmd_checker board;
  bit hold_results;
  bit no_gaps;
  int bytes_sent;

  text_console_cursor_engine_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_byte_in     (in_byte_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_op         (out_op),
    .out_glyph_code (out_glyph_code),
    .out_text_row   (out_text_row),
    .out_text_col   (out_text_col),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) board.note_byte(in_byte_in);
    if (rst_n && out_pop && !out_empty)
      board.check_cmd({out_op, out_glyph_code, out_text_row, out_text_col, out_last});
  end

  initial begin : result_sink
    int gap;
    out_pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_results) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
          out_pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (board.due_cmds.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(CH_SPACE, CH_DEL - 1));
  endfunction

  // carriage return, tabs out to column 120, then text up to or across the right edge
  task automatic send_edge_line();
    send_byte(CH_CR);
    repeat (15) send_byte(CH_TAB);
    repeat ($urandom_range(7, 9)) send_byte(printable());
  endtask

  logic [7:0] directed_bytes[$] = '{
    CH_BS, 8'h41, CH_SPACE, 8'h7E, CH_DEL, 8'h00, 8'hFF, CH_BS, CH_TAB, 8'h2A,
    CH_TAB, CH_BS, CH_CR, CH_NL, 8'd11, 8'd31, 8'h80, 8'h55, CH_FF, 8'h3F,
    CH_NL, 8'hAA, CH_TAB, CH_CR
  };

  initial begin : stimulus
    int kind;
    int len;
    int target;
    bit paused;
    board = new();
    rst_n <= 1'b0;
    in_push <= 1'b0;
    in_byte_in <= '0;
    hold_results = 1'b0;
    no_gaps = 1'b0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
    wait_drained();

    // result side stalls while bytes keep coming, so the input backs up
    hold_results = 1'b1;
    no_gaps = 1'b1;
    repeat (24) send_byte(($urandom_range(0, 4) == 0) ? CH_NL : printable());
    no_gaps = 1'b0;

    target = bytes_sent + RANDOM_BYTES;
    paused = 1'b0;
    send_edge_line();
    repeat ($urandom_range(62, 68)) send_byte(CH_NL);
    while (bytes_sent < target) begin
      if (!paused && bytes_sent > target - RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        repeat ($urandom_range(1, 24)) send_byte(printable());
      end else if (kind < 55) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 4);
        repeat (len) send_byte(($urandom_range(0, 7) == 0) ? CH_CR : CH_NL);
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 17)) send_byte(CH_TAB);
      end else if (kind < 73) begin
        repeat ($urandom_range(1, 10)) send_byte(CH_BS);
      end else if (kind < 80) begin
        send_edge_line();
      end else if (kind < 84) begin
        send_byte(CH_FF);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end

    wait_drained();
    repeat (24) @(posedge clk);
    if (board.errors == 0 && board.due_cmds.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
